@@ rtl/core/cabpw_pkg.sv @@
// ----------------------------------------------------------------------------
// cabpw_pkg
// Shared types and constants for the clipped alpha-blend pixel writer.
// ----------------------------------------------------------------------------
package cabpw_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned DimW      = 13;
  localparam int unsigned StrideW   = 14;
  localparam int unsigned AddrW     = 25;
  localparam int unsigned CmpW      = (CoordBits > DimW) ? CoordBits : DimW;
  localparam int unsigned YProdW    = DimW + StrideW;
  localparam int unsigned MixW      = 16;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned AlphaLsb  = 24;

  localparam logic [7:0]         ChanMax      = 8'hFF;
  localparam logic [DimW-1:0]    WidthReset   = 13'd640;
  localparam logic [DimW-1:0]    HeightReset  = 13'd480;
  localparam logic [StrideW-1:0] StrideReset  = 14'd640;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegStride = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic [31:0]                 src_argb;
    logic [31:0]                 dst_argb;
  } in_req_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] pixel_address;
    logic [31:0]      write_argb;
  } result_t;

  typedef struct packed {
    logic [DimW-1:0]    screen_width;
    logic [DimW-1:0]    screen_height;
    logic [StrideW-1:0] row_stride;
  } cfg_t;

  // after the clip stage
  typedef struct packed {
    logic            on_screen;
    logic            alpha_full;
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [31:0]     src;
    logic [31:0]     dst;
  } clip_t;

  // after the multiply stage
  typedef struct packed {
    logic                         on_screen;
    logic                         alpha_full;
    logic [DimW-1:0]              x;
    logic [YProdW-1:0]            y_prod;
    logic [31:0]                  src;
    logic [NumChan-1:0][MixW-1:0] mix;
  } mult_t;

endpackage

@@ rtl/core/cabpw_regs.sv @@
// ----------------------------------------------------------------------------
// cabpw_regs
// APB register file holding screen width, height and row stride.
// ----------------------------------------------------------------------------
module cabpw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cabpw_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cabpw_pkg::cfg_t               cfg_o
);

  cabpw_pkg::cfg_t cfg_d, cfg_q;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cabpw_pkg::RegWidth:  cfg_d.screen_width  = pwdata[cabpw_pkg::DimW-1:0];
        cabpw_pkg::RegHeight: cfg_d.screen_height = pwdata[cabpw_pkg::DimW-1:0];
        cabpw_pkg::RegStride: cfg_d.row_stride    = pwdata[cabpw_pkg::StrideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cabpw_pkg::RegWidth:  prdata = 32'(cfg_q.screen_width);
      cabpw_pkg::RegHeight: prdata = 32'(cfg_q.screen_height);
      cabpw_pkg::RegStride: prdata = 32'(cfg_q.row_stride);
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= cabpw_pkg::WidthReset;
      cfg_q.screen_height <= cabpw_pkg::HeightReset;
      cfg_q.row_stride    <= cabpw_pkg::StrideReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/cabpw_clip.sv @@
// ----------------------------------------------------------------------------
// cabpw_clip
// Stage one: clip test against the screen and alpha check.
// ----------------------------------------------------------------------------
module cabpw_clip (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cabpw_pkg::in_req_t   req_i,
  input  cabpw_pkg::cfg_t      cfg_i,
  output logic                 valid_o,
  output cabpw_pkg::clip_t     clip_o
);

  logic [cabpw_pkg::CmpW-1:0] x_ext, y_ext;
  logic                       valid_d, valid_q;
  cabpw_pkg::clip_t           clip_d, clip_q;

  always_comb begin
    x_ext = cabpw_pkg::CmpW'($unsigned(req_i.pos_x));
    y_ext = cabpw_pkg::CmpW'($unsigned(req_i.pos_y));
    clip_d.on_screen = !req_i.pos_x[cabpw_pkg::CoordBits-1] &&
                       !req_i.pos_y[cabpw_pkg::CoordBits-1] &&
                       (x_ext < cabpw_pkg::CmpW'(cfg_i.screen_width)) &&
                       (y_ext < cabpw_pkg::CmpW'(cfg_i.screen_height));
    clip_d.alpha_full = (req_i.src_argb[31:cabpw_pkg::AlphaLsb] == cabpw_pkg::ChanMax);
    clip_d.x   = x_ext[cabpw_pkg::DimW-1:0];
    clip_d.y   = y_ext[cabpw_pkg::DimW-1:0];
    clip_d.src = req_i.src_argb;
    clip_d.dst = req_i.dst_argb;
    valid_d    = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
  end

  assign valid_o = valid_q;
  assign clip_o  = clip_q;

endmodule

@@ rtl/core/cabpw_mult.sv @@
// ----------------------------------------------------------------------------
// cabpw_mult
// Stage two: row offset product and weighted channel sums.
// ----------------------------------------------------------------------------
module cabpw_mult (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cabpw_pkg::clip_t     clip_i,
  input  cabpw_pkg::cfg_t      cfg_i,
  output logic                 valid_o,
  output cabpw_pkg::mult_t     mult_o
);

  logic [cabpw_pkg::MixW-1:0] alpha, alpha_inv;
  logic                       valid_q;
  cabpw_pkg::mult_t           mult_d, mult_q;

  always_comb begin
    alpha     = cabpw_pkg::MixW'(clip_i.src[31:cabpw_pkg::AlphaLsb]);
    alpha_inv = cabpw_pkg::MixW'(cabpw_pkg::ChanMax - clip_i.src[31:cabpw_pkg::AlphaLsb]);
    mult_d.on_screen  = clip_i.on_screen;
    mult_d.alpha_full = clip_i.alpha_full;
    mult_d.x          = clip_i.x;
    mult_d.src        = clip_i.src;
    mult_d.y_prod     = cabpw_pkg::YProdW'(clip_i.y) * cabpw_pkg::YProdW'(cfg_i.row_stride);
    // sum stays at or below 255*255
    for (int c = 0; c < cabpw_pkg::NumChan; c++) begin
      mult_d.mix[c] = cabpw_pkg::MixW'(clip_i.src[8*c +: 8]) * alpha +
                      cabpw_pkg::MixW'(clip_i.dst[8*c +: 8]) * alpha_inv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mult_q <= mult_d;
  end

  assign valid_o = valid_q;
  assign mult_o  = mult_q;

endmodule

@@ rtl/core/cabpw_out.sv @@
// ----------------------------------------------------------------------------
// cabpw_out
// Stage three: address sum, divide by 255 and result register.
// ----------------------------------------------------------------------------
module cabpw_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cabpw_pkg::mult_t     mult_i,
  output logic                 valid_o,
  output cabpw_pkg::result_t   result_o
);

  logic [cabpw_pkg::YProdW:0]                  addr_sum;
  logic [cabpw_pkg::NumChan-1:0][cabpw_pkg::MixW:0] div_tmp;
  logic [23:0]                                 rgb;
  logic                                        valid_q;
  cabpw_pkg::result_t                          result_d, result_q;

  always_comb begin
    addr_sum = (cabpw_pkg::YProdW+1)'(mult_i.y_prod) + (cabpw_pkg::YProdW+1)'(mult_i.x);
    // n/255 as (n + (n>>8) + 1) >> 8, exact over the blend range
    for (int c = 0; c < cabpw_pkg::NumChan; c++) begin
      div_tmp[c] = (cabpw_pkg::MixW+1)'(mult_i.mix[c]) +
                   (cabpw_pkg::MixW+1)'(mult_i.mix[c][cabpw_pkg::MixW-1:8]) +
                   (cabpw_pkg::MixW+1)'(1);
      rgb[8*c +: 8] = div_tmp[c][15:8];
    end
    result_d.write_enable  = mult_i.on_screen;
    result_d.pixel_address = '0;
    result_d.write_argb    = '0;
    if (mult_i.on_screen) begin
      result_d.pixel_address = addr_sum[cabpw_pkg::AddrW-1:0];
      result_d.write_argb    = mult_i.alpha_full ? mult_i.src : {8'h00, rgb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ rtl/core/clipped_alpha_blend_pixel_write_top.sv @@
// ----------------------------------------------------------------------------
// clipped_alpha_blend_pixel_write_top
// Clips a pixel to the screen, blends ARGB8888 source over destination and
// forms the frame store write address.
// ----------------------------------------------------------------------------
// channel   | ports                                      | handshake
// request   | start_i, busy_o, in_req_i                  | taken when start_i && !busy_o
// result    | result_valid_o, result_o                   | one-cycle strobe, no stall
// config    | psel, penable, pwrite, paddr, pwdata,      | APB, pready tied high
//           | prdata, pready                             |
//
// one request per cycle; each result passes the clip, multiply and output registers in turn
// stages: clip test, multiplies (y*stride and channel weights), add and /255
// busy_o stays low since the result side never stalls
// reset clears pipeline valid bits and loads the default screen geometry
// ----------------------------------------------------------------------------
module clipped_alpha_blend_pixel_write_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  cabpw_pkg::in_req_t             in_req_i,
  output logic                           result_valid_o,
  output cabpw_pkg::result_t             result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cabpw_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  cabpw_pkg::cfg_t  cfg;
  cabpw_pkg::clip_t clip;
  cabpw_pkg::mult_t mult;
  logic             clip_valid, mult_valid;

  assign busy_o = 1'b0;

  cabpw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cabpw_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (in_req_i),
    .cfg_i   (cfg),
    .valid_o (clip_valid),
    .clip_o  (clip)
  );

  cabpw_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (clip_valid),
    .clip_i  (clip),
    .cfg_i   (cfg),
    .valid_o (mult_valid),
    .mult_o  (mult)
  );

  cabpw_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mult_valid),
    .mult_i   (mult),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

@@ rtl/core/cabpw_checker.sv @@
// ----------------------------------------------------------------------------
// cabpw_checker
// Port-level checks for the pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
module cabpw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input cabpw_pkg::result_t result_o
);

  // every request yields a result once it has passed the clip, multiply and output registers
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 result_valid_o)
    else $error("request did not produce a result");

  // no result without a request
  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a request");

  // clipped pixels carry zero address and data
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.write_enable) |->
      (result_o.pixel_address == '0 && result_o.write_argb == '0))
    else $error("clipped result not zeroed");

  // blended words carry alpha zero
  a_blend_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.write_enable && result_o.write_argb[31:24] != 8'hFF) |->
      (result_o.write_argb[31:24] == 8'h00))
    else $error("blended word has nonzero alpha");

endmodule

bind clipped_alpha_blend_pixel_write_top cabpw_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
